### sv/multi_tap_hermite_delay_line_assert.svh
// assertion macros for the multi-tap hermite delay line
`ifndef MULTI_TAP_HERMITE_DELAY_LINE_ASSERT_SVH
`define MULTI_TAP_HERMITE_DELAY_LINE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication, silent during reset
`define MTHDL_ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("mthdl assertion failed");
// next-cycle implication, silent during reset
`define MTHDL_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("mthdl assertion failed");
`else
`define MTHDL_ASSERT_IMPLIES(label, clk, rst, cond, expr)
`define MTHDL_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif

`endif

### sv/mthdl_pkg.sv
// shared constants of the multi-tap hermite delay line
package mthdl_pkg;

   localparam int unsigned DEPTH_DEFAULT       = 65536;
   localparam int unsigned FRAC_BITS_DEFAULT   = 16;
   localparam int unsigned SAMPLE_BITS_DEFAULT = 24;

   // delay fields are fixed Q16.16 words on the channel
   localparam int unsigned DELAY_BITS = 32;

   localparam int unsigned HEADS     = 3;
   localparam int unsigned BANKS     = 4;
   localparam int unsigned BANK_BITS = 2;

   // tap order inside one head
   localparam int unsigned TAP_XM1 = 0;
   localparam int unsigned TAP_X0  = 1;
   localparam int unsigned TAP_X1  = 2;
   localparam int unsigned TAP_X2  = 3;

endpackage

### sv/mthdl_if.sv
// request and response channel interfaces of the delay line

interface mthdl_req_if #(
   parameter int unsigned SAMPLE_BITS = mthdl_pkg::SAMPLE_BITS_DEFAULT
) ();
   import mthdl_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] record_sample;
   logic        [DELAY_BITS-1:0]  delay_head_one;
   logic        [DELAY_BITS-1:0]  delay_head_two;
   logic        [DELAY_BITS-1:0]  delay_head_three;

   modport source (
      output valid, record_sample, delay_head_one, delay_head_two, delay_head_three,
      input  ready
   );
   modport sink (
      input  valid, record_sample, delay_head_one, delay_head_two, delay_head_three,
      output ready
   );
endinterface

interface mthdl_rsp_if #(
   parameter int unsigned SAMPLE_BITS = mthdl_pkg::SAMPLE_BITS_DEFAULT
) ();
   import mthdl_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] head_one_sample;
   logic signed [SAMPLE_BITS-1:0] head_two_sample;
   logic signed [SAMPLE_BITS-1:0] head_three_sample;

   modport source (
      output valid, head_one_sample, head_two_sample, head_three_sample,
      input  ready
   );
   modport sink (
      input  valid, head_one_sample, head_two_sample, head_three_sample,
      output ready
   );
endinterface

### sv/multi_tap_hermite_delay_line.sv
// top level: three-head fractional delay line with 4-point hermite interpolation
// throughput: one beat per cycle without back-pressure; each head owns four sample banks, one read port each
// reset: write position, fill tracking and pipeline valid flags clear
// the sample store gets no clearing pass: entries never written read as zero
// through the fill tracking, so the block takes beats as soon as reset ends
module multi_tap_hermite_delay_line #(
   parameter int unsigned DEPTH       = mthdl_pkg::DEPTH_DEFAULT,
   parameter int unsigned FRAC_BITS   = mthdl_pkg::FRAC_BITS_DEFAULT,
   parameter int unsigned SAMPLE_BITS = mthdl_pkg::SAMPLE_BITS_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   mthdl_req_if.sink   req_bus,
   mthdl_rsp_if.source rsp_bus
);
   import mthdl_pkg::*;

`include "multi_tap_hermite_delay_line_assert.svh"

   // widths
   localparam int unsigned AW   = $clog2(DEPTH);           // store index
   localparam int unsigned PW   = AW + FRAC_BITS;          // fixed-point read position
   localparam int unsigned CW   = (PW > DELAY_BITS) ? PW : DELAY_BITS; // clamp compare
   localparam int unsigned RW   = AW - BANK_BITS;          // bank row
   localparam int unsigned ROWS = DEPTH / BANKS;
   localparam int unsigned SB   = SAMPLE_BITS;
   localparam int unsigned F    = FRAC_BITS;
   localparam int unsigned XW   = SB + 4;                  // coefficient arithmetic
   localparam int unsigned AWD  = SB + 3;                  // coefficient a
   localparam int unsigned BWD  = SB + 4;                  // coefficient b
   localparam int unsigned CWD  = SB + 1;                  // coefficient c
   localparam int unsigned RIW  = SB + 5;                  // horner remainders
   localparam int unsigned PAW  = AWD + F + 1;             // a times f
   localparam int unsigned PBW  = RIW + F + 1;             // remainder times f
   localparam int unsigned NS   = 10;                      // pipeline stages
   localparam int unsigned TAPS = BANKS;

   localparam logic [CW-1:0] DLY_LO = CW'(4) << F;
   localparam logic [CW-1:0] DLY_HI = CW'(DEPTH - 8) << F;

   // rounding offsets, ties go towards plus infinity
   localparam logic signed [PAW:0] HALF_A = (PAW + 1)'(1) <<< (F - 1);
   localparam logic signed [PBW:0] HALF_B = (PBW + 1)'(1) <<< (F - 1);
   localparam logic signed [PBW:0] HALF_C = (PBW + 1)'(1) <<< F;
   localparam logic signed [PBW:0] SMP_MAX = ((PBW + 1)'(1) <<< (SB - 1)) - (PBW + 1)'(1);
   localparam logic signed [PBW:0] SMP_MIN = -SMP_MAX - (PBW + 1)'(1);

   // ---------------------------------------------------------------
   // flow control: every stage loads when empty or when it drains
   // ---------------------------------------------------------------
   logic [NS-1:0] v_ff;
   logic [NS-1:0] stage_en;
   logic          req_accept;

   always_comb begin
      stage_en[NS-1] = !v_ff[NS-1] || rsp_bus.ready;
      for (int i = NS - 2; i >= 0; i--) begin
         stage_en[i] = !v_ff[i] || stage_en[i+1];
      end
   end

   assign req_bus.ready = stage_en[0];
   assign req_accept    = req_bus.valid && stage_en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (stage_en[0]) begin
            v_ff[0] <= req_bus.valid;
         end
         for (int i = 1; i < NS; i++) begin
            if (stage_en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   // write position and fill tracking, stamped on each beat at acceptance
   logic [AW-1:0] wp_ff;
   logic          wrap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         wrap_ff <= 1'b0;
      end else if (req_accept) begin
         wp_ff <= wp_ff + AW'(1);
         if (wp_ff == AW'(DEPTH - 1)) begin
            wrap_ff <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // stage 0: delay saturation
   // ---------------------------------------------------------------
   logic        [DELAY_BITS-1:0] dly_raw [HEADS];
   logic        [PW-1:0]         s0_dly_in [HEADS];
   logic        [PW-1:0]         s0_dly_ff [HEADS];
   logic signed [SB-1:0]         s0_sample_ff;
   logic        [AW-1:0]         s0_wp_ff;
   logic                         s0_wrap_ff;

   assign dly_raw[0] = req_bus.delay_head_one;
   assign dly_raw[1] = req_bus.delay_head_two;
   assign dly_raw[2] = req_bus.delay_head_three;

   always_comb begin
      logic [CW-1:0] d;
      for (int h = 0; h < HEADS; h++) begin
         d = CW'(dly_raw[h]);
         if (d < DLY_LO) begin
            d = DLY_LO;
         end else if (d > DLY_HI) begin
            d = DLY_HI;
         end
         s0_dly_in[h] = d[PW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s0_sample_ff <= req_bus.record_sample;
         s0_wp_ff     <= wp_ff;
         s0_wrap_ff   <= wrap_ff;
         s0_dly_ff    <= s0_dly_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 1: read position = write position minus delay, wrapped
   // ---------------------------------------------------------------
   logic        [AW-1:0] s1_base_in [HEADS];
   logic        [F-1:0]  s1_frac_in [HEADS];
   logic        [AW-1:0] s1_base_ff [HEADS];
   logic        [F-1:0]  s1_frac_ff [HEADS];
   logic signed [SB-1:0] s1_sample_ff;
   logic        [AW-1:0] s1_wp_ff;
   logic                 s1_wrap_ff;

   always_comb begin
      logic [PW-1:0] rp;
      for (int h = 0; h < HEADS; h++) begin
         rp            = {s0_wp_ff, {F{1'b0}}} - s0_dly_ff[h];
         s1_base_in[h] = rp[PW-1:F];
         s1_frac_in[h] = rp[F-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         s1_sample_ff <= s0_sample_ff;
         s1_wp_ff     <= s0_wp_ff;
         s1_wrap_ff   <= s0_wrap_ff;
         s1_base_ff   <= s1_base_in;
         s1_frac_ff   <= s1_frac_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 2: banked store, read of the old contents and write of the new sample
   // the four taps of a head are consecutive, so they land in four distinct banks
   // ---------------------------------------------------------------
   logic [AW-1:0]        tap_idx [HEADS][BANKS];
   logic [RW-1:0]        rd_row  [HEADS][BANKS];
   logic [BANKS-1:0]     s2_ok_in [HEADS];
   logic [BANKS-1:0]     s2_ok_ff [HEADS];
   logic [BANK_BITS-1:0] s2_lo_ff [HEADS];
   logic [F-1:0]         s2_frac_ff [HEADS];
   logic [SB-1:0]        rd_data [HEADS][BANKS];
   logic                 mem_wr_en;
   logic [BANK_BITS-1:0] wr_bank;
   logic [RW-1:0]        wr_row;
   logic                 tap_hit;

   assign mem_wr_en = stage_en[2] && v_ff[1];
   assign wr_bank   = s1_wp_ff[BANK_BITS-1:0];
   assign wr_row    = s1_wp_ff[AW-1:BANK_BITS];

   always_comb begin
      logic [BANK_BITS-1:0] k;
      tap_hit = 1'b0;
      for (int h = 0; h < HEADS; h++) begin
         for (int b = 0; b < BANKS; b++) begin
            // which tap of this head falls in bank b
            k = BANK_BITS'(b) + BANK_BITS'(1) - s1_base_ff[h][BANK_BITS-1:0];
            tap_idx[h][b] = s1_base_ff[h] + AW'(k) - AW'(1);
            rd_row[h][b]  = tap_idx[h][b][AW-1:BANK_BITS];
            // before the first wrap only indices below the write position hold data
            s2_ok_in[h][b] = s1_wrap_ff || (tap_idx[h][b] < s1_wp_ff);
            if (tap_idx[h][b] == s1_wp_ff) begin
               tap_hit = 1'b1;
            end
         end
      end
   end

   for (genvar h = 0; h < HEADS; h++) begin : g_head
      for (genvar b = 0; b < BANKS; b++) begin : g_bank
         logic [SB-1:0] bank_mem [ROWS];
         logic [SB-1:0] bank_q_ff;

         always_ff @(posedge clock) begin
            if (mem_wr_en && (wr_bank == BANK_BITS'(b))) begin
               bank_mem[wr_row] <= s1_sample_ff;
            end
            if (stage_en[2]) begin
               bank_q_ff <= bank_mem[rd_row[h][b]];
            end
         end

         assign rd_data[h][b] = bank_q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         s2_ok_ff   <= s2_ok_in;
         s2_frac_ff <= s1_frac_ff;
         for (int h = 0; h < HEADS; h++) begin
            s2_lo_ff[h] <= s1_base_ff[h][BANK_BITS-1:0];
         end
      end
   end

   // ---------------------------------------------------------------
   // stage 3: tap reorder and hermite coefficients, kept at twice their value
   // ---------------------------------------------------------------
   logic signed [SB-1:0]  s3_x0_in [HEADS];
   logic signed [AWD-1:0] s3_a_in  [HEADS];
   logic signed [BWD-1:0] s3_b_in  [HEADS];
   logic signed [CWD-1:0] s3_c_in  [HEADS];
   logic signed [SB-1:0]  s3_x0_ff [HEADS];
   logic signed [AWD-1:0] s3_a_ff  [HEADS];
   logic signed [BWD-1:0] s3_b_ff  [HEADS];
   logic signed [CWD-1:0] s3_c_ff  [HEADS];
   logic        [F-1:0]   s3_frac_ff [HEADS];

   always_comb begin
      logic        [BANK_BITS-1:0] bsel;
      logic signed [SB-1:0]        tap [TAPS];
      logic signed [XW-1:0]        xm1, x0, x1, x2, c, v, w, a, b;
      for (int h = 0; h < HEADS; h++) begin
         for (int t = 0; t < TAPS; t++) begin
            bsel   = s2_lo_ff[h] + BANK_BITS'(t + BANKS - 1);
            tap[t] = s2_ok_ff[h][bsel] ? signed'(rd_data[h][bsel]) : '0;
         end
         xm1 = XW'(tap[TAP_XM1]);
         x0  = XW'(tap[TAP_X0]);
         x1  = XW'(tap[TAP_X1]);
         x2  = XW'(tap[TAP_X2]);
         c   = x1 - xm1;
         v   = (x0 - x1) <<< 1;
         w   = c + v;
         a   = w + v + (x2 - x0);
         b   = w + a;
         s3_x0_in[h] = tap[TAP_X0];
         s3_a_in[h]  = a[AWD-1:0];
         s3_b_in[h]  = b[BWD-1:0];
         s3_c_in[h]  = c[CWD-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         s3_x0_ff   <= s3_x0_in;
         s3_a_ff    <= s3_a_in;
         s3_b_ff    <= s3_b_in;
         s3_c_ff    <= s3_c_in;
         s3_frac_ff <= s2_frac_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 4: a times f
   // ---------------------------------------------------------------
   logic signed [PAW-1:0] s4_pa_in [HEADS];
   logic signed [PAW-1:0] s4_pa_ff [HEADS];
   logic signed [BWD-1:0] s4_b_ff  [HEADS];
   logic signed [CWD-1:0] s4_c_ff  [HEADS];
   logic signed [SB-1:0]  s4_x0_ff [HEADS];
   logic        [F-1:0]   s4_frac_ff [HEADS];

   always_comb begin
      logic signed [F:0] fx;
      for (int h = 0; h < HEADS; h++) begin
         fx          = signed'({1'b0, s3_frac_ff[h]});
         s4_pa_in[h] = s3_a_ff[h] * fx;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         s4_pa_ff   <= s4_pa_in;
         s4_b_ff    <= s3_b_ff;
         s4_c_ff    <= s3_c_ff;
         s4_x0_ff   <= s3_x0_ff;
         s4_frac_ff <= s3_frac_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 5: r1 = round(a f) - b
   // ---------------------------------------------------------------
   logic signed [RIW-1:0] s5_r1_in [HEADS];
   logic signed [RIW-1:0] s5_r1_ff [HEADS];
   logic signed [CWD-1:0] s5_c_ff  [HEADS];
   logic signed [SB-1:0]  s5_x0_ff [HEADS];
   logic        [F-1:0]   s5_frac_ff [HEADS];

   always_comb begin
      logic signed [PAW:0] t;
      for (int h = 0; h < HEADS; h++) begin
         t           = ((PAW + 1)'(s4_pa_ff[h]) + HALF_A) >>> F;
         t           = t - (PAW + 1)'(s4_b_ff[h]);
         s5_r1_in[h] = t[RIW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         s5_r1_ff   <= s5_r1_in;
         s5_c_ff    <= s4_c_ff;
         s5_x0_ff   <= s4_x0_ff;
         s5_frac_ff <= s4_frac_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 6: r1 times f
   // ---------------------------------------------------------------
   logic signed [PBW-1:0] s6_pb_in [HEADS];
   logic signed [PBW-1:0] s6_pb_ff [HEADS];
   logic signed [CWD-1:0] s6_c_ff  [HEADS];
   logic signed [SB-1:0]  s6_x0_ff [HEADS];
   logic        [F-1:0]   s6_frac_ff [HEADS];

   always_comb begin
      logic signed [F:0] fx;
      for (int h = 0; h < HEADS; h++) begin
         fx          = signed'({1'b0, s5_frac_ff[h]});
         s6_pb_in[h] = s5_r1_ff[h] * fx;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         s6_pb_ff   <= s6_pb_in;
         s6_c_ff    <= s5_c_ff;
         s6_x0_ff   <= s5_x0_ff;
         s6_frac_ff <= s5_frac_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 7: r2 = round(r1 f) + c
   // ---------------------------------------------------------------
   logic signed [RIW-1:0] s7_r2_in [HEADS];
   logic signed [RIW-1:0] s7_r2_ff [HEADS];
   logic signed [SB-1:0]  s7_x0_ff [HEADS];
   logic        [F-1:0]   s7_frac_ff [HEADS];

   always_comb begin
      logic signed [PBW:0] t;
      for (int h = 0; h < HEADS; h++) begin
         t           = ((PBW + 1)'(s6_pb_ff[h]) + HALF_B) >>> F;
         t           = t + (PBW + 1)'(s6_c_ff[h]);
         s7_r2_in[h] = t[RIW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[7]) begin
         s7_r2_ff   <= s7_r2_in;
         s7_x0_ff   <= s6_x0_ff;
         s7_frac_ff <= s6_frac_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 8: r2 times f
   // ---------------------------------------------------------------
   logic signed [PBW-1:0] s8_pc_in [HEADS];
   logic signed [PBW-1:0] s8_pc_ff [HEADS];
   logic signed [SB-1:0]  s8_x0_ff [HEADS];

   always_comb begin
      logic signed [F:0] fx;
      for (int h = 0; h < HEADS; h++) begin
         fx          = signed'({1'b0, s7_frac_ff[h]});
         s8_pc_in[h] = s7_r2_ff[h] * fx;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[8]) begin
         s8_pc_ff <= s8_pc_in;
         s8_x0_ff <= s7_x0_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 9: y = x0 + round(r2 f / 2), saturated; this is the output register
   // ---------------------------------------------------------------
   logic signed [SB-1:0] s9_y_in [HEADS];
   logic signed [SB-1:0] s9_y_ff [HEADS];

   always_comb begin
      logic signed [PBW:0] t;
      for (int h = 0; h < HEADS; h++) begin
         t = ((PBW + 1)'(s8_pc_ff[h]) + HALF_C) >>> (F + 1);
         t = t + (PBW + 1)'(s8_x0_ff[h]);
         if (t > SMP_MAX) begin
            t = SMP_MAX;
         end else if (t < SMP_MIN) begin
            t = SMP_MIN;
         end
         s9_y_in[h] = t[SB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[9]) begin
         s9_y_ff <= s9_y_in;
      end
   end

   assign rsp_bus.valid             = v_ff[NS-1];
   assign rsp_bus.head_one_sample   = s9_y_ff[0];
   assign rsp_bus.head_two_sample   = s9_y_ff[1];
   assign rsp_bus.head_three_sample = s9_y_ff[2];

   // ---------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------
   // saturated delays keep every tap off the slot being written
   `MTHDL_ASSERT_IMPLIES(a_tap_clear_of_write, clock, reset, mem_wr_en, !tap_hit)
   // a stalled beat in the store stage keeps its read data
   `MTHDL_ASSERT_NEXT(a_store_stage_holds, clock, reset, v_ff[2] && !stage_en[2], v_ff[2] && $stable(rd_data[0][0]) && $stable(s2_frac_ff[0]))
   // the last slot wraps the write position and marks the store full
   `MTHDL_ASSERT_NEXT(a_wrap_marks_full, clock, reset, req_accept && (wp_ff == AW'(DEPTH - 1)), wrap_ff && (wp_ff == '0))

endmodule

### tb/multi_tap_hermite_delay_line_test.sv
// self-checking testbench of the three-head hermite delay line, with its own interpolation model
module multi_tap_hermite_delay_line_test;
   timeunit 1ns;
   timeprecision 1ps;

   import mthdl_pkg::*;

   localparam int unsigned DEPTH       = DEPTH_DEFAULT;
   localparam int unsigned FRAC_BITS   = FRAC_BITS_DEFAULT;
   localparam int unsigned SAMPLE_BITS = SAMPLE_BITS_DEFAULT;
   localparam int unsigned IDX_BITS    = $clog2(DEPTH);
   localparam int unsigned POS_BITS    = IDX_BITS + FRAC_BITS;

   // delay limits in Q16.16, both exact at the fractional resolution
   localparam logic [DELAY_BITS-1:0] DELAY_FLOOR = 4 << FRAC_BITS;
   localparam logic [DELAY_BITS-1:0] DELAY_CEIL  = (DEPTH - 8) << FRAC_BITS;

   localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   localparam int unsigned RANDOM_ITEMS   = 388;
   localparam int unsigned CALM_ITEMS     = 60;
   localparam int unsigned HOLD_CYCLES    = 80;
   localparam int unsigned DRAIN_CYCLES   = 20;
   localparam int unsigned WATCHDOG_LIMIT = 1000;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [DELAY_BITS-1:0]         delay_type;
   typedef struct { sample_type heads [HEADS]; } head_reads_type;

   // tape model: reads all three heads from the old contents, then records
   class delay_line_scoreboard;
      sample_type          tape [DEPTH];
      logic [IDX_BITS-1:0] write_pos;
      head_reads_type      awaited_reads [$];
      int unsigned         errors;
      string               head_name [HEADS] = '{"one", "two", "three"};

      function new();
         foreach (tape[i]) tape[i] = '0;
         write_pos = '0;
         errors    = 0;
      endfunction

      // divide by 2^s, nearest, ties towards plus infinity
      static function longint round_half_up(longint p, int unsigned s);
         return (p + (longint'(1) << (s - 1))) >>> s;
      endfunction

      function sample_type interpolate_head(delay_type delay_word);
         delay_type           d;
         logic [POS_BITS-1:0] pos;
         logic [IDX_BITS-1:0] base, before_base, after_base, two_after;
         longint              f, xm1, x0, x1, x2, c, v, w, a, b, r, y;
         d = delay_word;
         if (d < DELAY_FLOOR) d = DELAY_FLOOR;
         if (d > DELAY_CEIL) d = DELAY_CEIL;
         pos         = {write_pos, {FRAC_BITS{1'b0}}} - POS_BITS'(d);
         base        = pos[POS_BITS-1:FRAC_BITS];
         f           = longint'(pos[FRAC_BITS-1:0]);
         before_base = base - 1'b1;
         after_base  = base + 1'b1;
         two_after   = base + 2'd2;
         xm1 = tape[before_base];
         x0  = tape[base];
         x1  = tape[after_base];
         x2  = tape[two_after];
         // coefficients held at twice their value
         c = x1 - xm1;
         v = 2 * (x0 - x1);
         w = c + v;
         a = w + v + (x2 - x0);
         b = w + a;
         r = round_half_up(a * f, FRAC_BITS) - b;
         r = round_half_up(r * f, FRAC_BITS) + c;
         y = x0 + round_half_up(r * f, FRAC_BITS + 1);
         if (y > longint'(SMP_MAX)) y = SMP_MAX;
         if (y < longint'(SMP_MIN)) y = SMP_MIN;
         return sample_type'(y);
      endfunction

      function void note_record(sample_type rec_sample, delay_type d_one, delay_type d_two,
                                delay_type d_three);
         head_reads_type due;
         due.heads[0] = interpolate_head(d_one);
         due.heads[1] = interpolate_head(d_two);
         due.heads[2] = interpolate_head(d_three);
         awaited_reads.push_back(due);
         tape[write_pos] = rec_sample;
         write_pos       = write_pos + 1'b1;
      endfunction

      function void check_heads(sample_type got_one, sample_type got_two,
                                sample_type got_three);
         head_reads_type due;
         sample_type     got [HEADS];
         got = '{got_one, got_two, got_three};
         if (awaited_reads.size() == 0) begin
            $display("%0t: response beat with nothing outstanding: %0d %0d %0d",
                     $time, got_one, got_two, got_three);
            errors++;
            return;
         end
         due = awaited_reads.pop_front();
         foreach (got[h]) begin
            if (got[h] !== due.heads[h]) begin
               $display("%0t: head %s expected %0d got %0d",
                        $time, head_name[h], due.heads[h], got[h]);
               errors++;
            end
         end
      endfunction

      function int unsigned outstanding();
         return awaited_reads.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   mthdl_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_bus ();
   mthdl_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_bus ();

   multi_tap_hermite_delay_line #(
      .DEPTH       (DEPTH),
      .FRAC_BITS   (FRAC_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   delay_line_scoreboard scoreboard = new();

   bit          calm         = 1'b0;  // no idling on either side once set
   bit          hold_request = 1'b0;  // asks the receiver for one long stall
   int unsigned stall_left   = 0;
   int unsigned quiet_cycles = 0;
   int unsigned sent         = 0;     // request beats accepted so far, i.e. next write position

   always #5 clock = ~clock;

   // offer one request beat, possibly after a short gap, and wait for its acceptance
   task automatic offer_record(input sample_type rec_sample, input delay_type d_one,
                               input delay_type d_two, input delay_type d_three);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_bus.valid            <= 1'b1;
      req_bus.record_sample    <= rec_sample;
      req_bus.delay_head_one   <= d_one;
      req_bus.delay_head_two   <= d_two;
      req_bus.delay_head_three <= d_three;
      do @(posedge clock); while (!req_bus.ready);
      sent++;
   endtask

   // delay that puts a head at the given Q16.16 tape position for the next beat
   function automatic delay_type delay_to(longint target);
      return delay_type'((longint'(sent) << FRAC_BITS) - target);
   endfunction

   function automatic delay_type random_delay();
      case ($urandom_range(0, 9))
         // close behind the write head, where recorded samples live
         0, 1, 2, 3, 4: return delay_type'($urandom_range(DELAY_FLOOR,
                                                         DELAY_FLOOR + (48 << FRAC_BITS)));
         5: return delay_type'($urandom());
         // around the upper limit, both sides of it
         6: return DELAY_CEIL - delay_type'($urandom_range(0, 3 << FRAC_BITS))
                   + delay_type'($urandom_range(0, 1 << FRAC_BITS));
         // below and just above the lower limit
         7: return delay_type'($urandom_range(0, DELAY_FLOOR + (2 << FRAC_BITS)));
         // anywhere over what has been recorded so far
         default: return delay_type'($urandom_range(DELAY_FLOOR, (sent + 8) << FRAC_BITS));
      endcase
   endfunction

   function automatic sample_type random_sample();
      case ($urandom_range(0, 7))
         0: return SMP_MAX;
         1: return SMP_MIN;
         default: return sample_type'($urandom());
      endcase
   endfunction

   // receiver: short random stalls, one long hold-off on request, none when calm
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left != 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = HOLD_CYCLES - 1;
            rsp_bus.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // both channels sampled at the edge, before the driven values move on
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            scoreboard.note_record(req_bus.record_sample, req_bus.delay_head_one,
                                   req_bus.delay_head_two, req_bus.delay_head_three);
         if (rsp_bus.valid && rsp_bus.ready)
            scoreboard.check_heads(rsp_bus.head_one_sample, rsp_bus.head_two_sample,
                                   rsp_bus.head_three_sample);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // watchdog: too long without a beat on either channel
   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("multi_tap_hermite_delay_line_test: FAIL");
      $finish;
   end

   initial begin
      // steep swings: positions two to five overshoot upwards, four to seven downwards
      sample_type swings [6];

      swings                   = '{SMP_MIN, SMP_MAX, SMP_MAX, SMP_MIN, SMP_MIN, SMP_MAX};
      reset                    <= 1'b1;
      req_bus.valid            <= 1'b0;
      req_bus.record_sample    <= '0;
      req_bus.delay_head_one   <= '0;
      req_bus.delay_head_two   <= '0;
      req_bus.delay_head_three <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // delays below, at and above both limits, reading an empty tape behind position zero
      offer_record(SMP_MAX, '0, '1, DELAY_FLOOR);
      offer_record(SMP_MIN, DELAY_FLOOR - 1, DELAY_CEIL, DELAY_CEIL + 1);
      foreach (swings[k])
         offer_record(swings[k], 32'h0004_8000, 32'h0005_FFFF, delay_type'($urandom()));

      // midpoint on the rising overshoot, and fractions next to an integer
      offer_record('0, delay_to(32'h0003_8000), delay_to(32'h0003_0001),
                   delay_to(32'h0003_FFFF));
      // neighbours wrapping round the top of the tape
      offer_record(sample_type'(1), delay_to(0),
                   delay_to((longint'(DEPTH - 1) << FRAC_BITS) + 32'h8000),
                   delay_to((longint'(DEPTH - 2) << FRAC_BITS) + 32'h4000));
      // midpoint on the falling overshoot; the last head is clamped up to the floor
      offer_record(sample_type'(-1), delay_to(32'h0005_8000), delay_to(32'h0002_4000),
                   delay_to(32'h0006_C000));
      offer_record(sample_type'(24'h555555), 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_FFFF);
      offer_record(sample_type'(24'hAAAAAA), 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_0000);

      // random beats: a long receiver hold-off a third of the way in, a calm tail
      for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) hold_request = 1'b1;
         if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
         offer_record(random_sample(), random_delay(), random_delay(), random_delay());
      end
      req_bus.valid <= 1'b0;

      // drain, then a little longer to catch stray response beats
      while (scoreboard.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (scoreboard.errors == 0)
         $display("multi_tap_hermite_delay_line_test: PASS");
      else
         $display("multi_tap_hermite_delay_line_test: FAIL");
      $finish;
   end

endmodule
